### rtl/core/trial_division_prime_counter_top_assert.svh
// assertion macros for the trial division prime counter
// used by the top level only; no other dependencies
`ifndef TRIAL_DIVISION_PRIME_COUNTER_TOP_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define TDPC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdpc same-cycle check failed");
// condition implies consequence in the next cycle
`define TDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdpc next-cycle check failed");
// condition holds at every edge out of reset
`define TDPC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("tdpc invariant failed");
`else
`define TDPC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TDPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`define TDPC_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

### rtl/core/tdpc_pkg.sv
// shared constants and types for the trial division prime counter
// used by the controller, the datapath and the top level
package tdpc_pkg;

   // port widths fixed by the interface
   localparam int CANDIDATE_BITS = 32;
   localparam int OUT_COUNT_BITS = 32;

   // internal sizing
   localparam int VALUE_BITS   = 32;
   localparam int COUNT_BITS   = 32;
   localparam int DIVISOR_BITS = (VALUE_BITS + 1) / 2 + 1;
   localparam int SQUARE_BITS  = VALUE_BITS + 1;
   localparam int STEP_BITS    = $clog2(VALUE_BITS);

   localparam int FIRST_DIVISOR = 2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_NEXT,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture a new request
      logic start_div;  // begin remainder for current divisor
      logic div_step;   // one remainder bit
      logic advance;    // move to the next divisor
      logic decide;     // latch the verdict
      logic verdict;    // prime flag to latch
      logic emit;       // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic below_two;  // candidate below two
      logic sq_gt;      // divisor squared exceeds candidate
      logic rem_zero;   // remainder is zero
      logic step_last;  // final remainder bit in progress
      logic out_free;   // result register can take a new result
   } status_type;

endpackage

### rtl/core/trial_division_prime_counter_top.sv
// top level of the trial division prime counter
// depends on tdpc_pkg, tdpc_ctrl, tdpc_datapath and the assertion header
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_candidate[31:0], req_last
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_is_prime, rsp_prime_count[31:0],
//           |           |                      | rsp_set_done
//
// one request at a time; values below four need only the load, check and result steps
// each divisor tried takes a check, 32 steps in the bit-serial remainder unit and an
// advance; a prime near 2^32 tries about 65534 divisors
// a new request is taken while a result waits in the output register
// reset clears the state machine, the running count and the result valid

`include "trial_division_prime_counter_top_assert.svh"

module trial_division_prime_counter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tdpc_pkg::CANDIDATE_BITS-1:0]  req_candidate,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_is_prime,
   output logic [tdpc_pkg::OUT_COUNT_BITS-1:0]  rsp_prime_count,
   output logic                                 rsp_set_done
);
   import tdpc_pkg::*;

   cmd_type    dp_cmd;
   status_type dp_status;
   logic [4:0] cmd_vec;

   // controller
   tdpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // datapath
   tdpc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_candidate   (req_candidate),
      .req_last        (req_last),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_prime_count (rsp_prime_count),
      .rsp_set_done    (rsp_set_done)
   );

   // checks
   assign cmd_vec = {dp_cmd.load, dp_cmd.start_div, dp_cmd.div_step, dp_cmd.advance,
                     dp_cmd.emit};

   `TDPC_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd_vec))
   `TDPC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `TDPC_ASSERT_IMPLIES(a_prime_counted, clock, reset, rsp_valid && rsp_is_prime, rsp_prime_count != '0)

endmodule

### rtl/core/tdpc_ctrl.sv
// controller state machine for the trial division prime counter
// depends on tdpc_pkg; drives commands into tdpc_datapath
module tdpc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tdpc_pkg::status_type  status,
   output tdpc_pkg::cmd_type     cmd
);
   import tdpc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_two) begin
               cmd.decide  = 1'b1;
               cmd.verdict = 1'b0;
               state_in    = ST_RESULT;
            end else if (status.sq_gt) begin
               cmd.decide  = 1'b1;
               cmd.verdict = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (status.rem_zero) begin
               cmd.decide  = 1'b1;
               cmd.verdict = 1'b0;
               state_in    = ST_RESULT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/tdpc_datapath.sv
// datapath: candidate, divisor and square registers, bit-serial remainder,
// running count and result register; depends on tdpc_pkg
module tdpc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [tdpc_pkg::CANDIDATE_BITS-1:0]    req_candidate,
   input  logic                                   req_last,
   input  tdpc_pkg::cmd_type                      cmd,
   output tdpc_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_is_prime,
   output logic [tdpc_pkg::OUT_COUNT_BITS-1:0]    rsp_prime_count,
   output logic                                   rsp_set_done
);
   import tdpc_pkg::*;

   logic [VALUE_BITS-1:0]   value_ff;
   logic                    last_ff;
   logic [DIVISOR_BITS-1:0] div_ff;
   logic [SQUARE_BITS-1:0]  sq_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] rem_in;
   logic [VALUE_BITS-1:0]   shift_ff;
   logic [STEP_BITS-1:0]    step_ff;
   logic                    prime_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_prime_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;
   logic                    rsp_last_ff;
   logic [DIVISOR_BITS:0]   trial;

   // one restoring step of the remainder
   always_comb begin
      trial = {rem_ff, shift_ff[VALUE_BITS-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = DIVISOR_BITS'(trial - {1'b0, div_ff});
      end else begin
         rem_in = DIVISOR_BITS'(trial);
      end
   end

   // saturating count including the current verdict
   always_comb begin
      count_in = count_ff;
      if (prime_ff && (count_ff != {COUNT_BITS{1'b1}})) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   // status back to the controller
   always_comb begin
      status.below_two = value_ff < VALUE_BITS'(FIRST_DIVISOR);
      status.sq_gt     = sq_ff > SQUARE_BITS'(value_ff);
      status.rem_zero  = rem_ff == '0;
      status.step_last = step_ff == '0;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // candidate, divisor and square
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= VALUE_BITS'(req_candidate);
         last_ff  <= req_last;
         div_ff   <= DIVISOR_BITS'(FIRST_DIVISOR);
         sq_ff    <= SQUARE_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
      end else if (cmd.advance) begin
         div_ff <= div_ff + DIVISOR_BITS'(1);
         sq_ff  <= sq_ff + SQUARE_BITS'({div_ff, 1'b1});
      end
   end

   // bit-serial remainder
   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         rem_ff   <= '0;
         shift_ff <= value_ff;
         step_ff  <= STEP_BITS'(VALUE_BITS - 1);
      end else if (cmd.div_step) begin
         rem_ff   <= rem_in;
         shift_ff <= {shift_ff[VALUE_BITS-2:0], 1'b0};
         step_ff  <= step_ff - STEP_BITS'(1);
      end
   end

   // verdict
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         prime_ff <= cmd.verdict;
      end
   end

   // running count, cleared after the closing request
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.emit) begin
         count_ff <= last_ff ? '0 : count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_prime_ff <= prime_ff;
         rsp_count_ff <= count_in;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_prime    = rsp_prime_ff;
   assign rsp_prime_count = OUT_COUNT_BITS'(rsp_count_ff);
   assign rsp_set_done    = rsp_last_ff;

endmodule

### tb/trial_division_prime_counter_top_tb.sv
// self-checking testbench for the trial division prime counter top level
// depends on tdpc_pkg and trial_division_prime_counter_top; reads no files
`timescale 1ns / 100ps

module trial_division_prime_counter_top_tb;

   localparam int          CAND_BITS    = tdpc_pkg::CANDIDATE_BITS;
   localparam int          RSP_BITS     = tdpc_pkg::OUT_COUNT_BITS;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int          HOLD_CYCLES  = 600;
   localparam int          DRAIN_CYCLES = 100;
   localparam longint unsigned VALUE_MASK =
      ((64'd1 << (tdpc_pkg::VALUE_BITS - 1)) << 1) - 64'd1;
   localparam longint unsigned COUNT_MAX =
      ((64'd1 << (tdpc_pkg::COUNT_BITS - 1)) << 1) - 64'd1;

   // one predicted response per accepted request
   typedef struct packed {
      logic [CAND_BITS-1:0] candidate;
      logic                 is_prime;
      logic [RSP_BITS-1:0]  prime_count;
      logic                 set_done;
   } verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CAND_BITS-1:0] req_candidate = '0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_is_prime;
   logic [RSP_BITS-1:0]  rsp_prime_count;
   logic                 rsp_set_done;

   verdict_type     pending_verdicts[$];
   verdict_type     next_verdict;
   longint unsigned open_set_primes = 0;
   int              error_count = 0;
   int unsigned     cycle_count = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   logic            hold_toggle = 1'b0;
   logic            hold_seen = 1'b0;
   int              hold_left = 0;

   trial_division_prime_counter_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_candidate   (req_candidate),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_prime_count (rsp_prime_count),
      .rsp_set_done    (rsp_set_done)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("trial_division_prime_counter_top_tb failed");
         $finish;
      end
   end

   // response ready: random stalls, plus a long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h",
               cycle_count, what, got, want);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_prime_count, 0);
         end else begin
            next_verdict = pending_verdicts.pop_front();
            if (rsp_is_prime !== next_verdict.is_prime)
               report_mismatch($sformatf("is_prime for %0d", next_verdict.candidate),
                               rsp_is_prime, next_verdict.is_prime);
            if (rsp_prime_count !== next_verdict.prime_count)
               report_mismatch($sformatf("prime_count for %0d", next_verdict.candidate),
                               rsp_prime_count, next_verdict.prime_count);
            if (rsp_set_done !== next_verdict.set_done)
               report_mismatch($sformatf("set_done for %0d", next_verdict.candidate),
                               rsp_set_done, next_verdict.set_done);
         end
      end
   end

   // primality by trial division up to the square root
   function automatic bit trial_prime(input longint unsigned n);
      longint unsigned d;
      if (n < tdpc_pkg::FIRST_DIVISOR)
         return 1'b0;
      for (d = tdpc_pkg::FIRST_DIVISOR; d <= n / d; d++) begin
         if (n % d == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // update the open set count and queue the response it implies
   task automatic predict_verdict(input logic [CAND_BITS-1:0] cand, input logic last);
      verdict_type v;
      v.candidate = cand;
      v.is_prime  = trial_prime(longint'(cand) & VALUE_MASK);
      if (v.is_prime && open_set_primes < COUNT_MAX)
         open_set_primes++;
      v.prime_count = open_set_primes[RSP_BITS-1:0];
      v.set_done    = last;
      pending_verdicts.push_back(v);
      if (last)
         open_set_primes = 0;
   endtask

   // offer one request, idling first at the current rate
   task automatic send_request(input logic [CAND_BITS-1:0] cand, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= cand;
      req_last      <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_verdict(cand, last);
   endtask

   task automatic set_rates(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // zero, one, two, three, prime squares, all-ones and top-bit patterns
   task automatic test_edge_values();
      set_rates(0, 0);
      send_request(0, 1'b0);
      send_request(1, 1'b0);
      send_request(2, 1'b0);
      send_request(3, 1'b0);
      send_request(4, 1'b0);
      send_request(5, 1'b1);
      send_request(9, 1'b0);
      send_request(25, 1'b0);
      send_request(49, 1'b0);
      send_request(7, 1'b0);
      send_request(11, 1'b0);
      send_request(13, 1'b1);
      // single-request sets
      send_request(2, 1'b1);
      send_request(1, 1'b1);
      // wide values with small factors keep the divisor search short
      send_request(32'hFFFF_FFFF, 1'b0);
      send_request(32'hFFFF_FFFE, 1'b0);
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h5555_5555, 1'b0);
      send_request(32'hAAAA_AAAA, 1'b0);
      send_request(31, 1'b1);
   endtask

   // longer divisor searches: medium primes and a prime square
   task automatic test_medium_primes();
      set_rates(0, 0);
      send_request(65521, 1'b0);
      send_request(1048573, 1'b0);
      send_request(1021 * 1021, 1'b1);
   endtask

   // receiver holds off while requests keep coming, so the input backs up
   task automatic test_output_holdoff();
      int i;
      set_rates(0, 0);
      hold_toggle <= ~hold_toggle;
      for (i = 0; i < 6; i++)
         send_request($urandom_range(2, 47), (i == 5));
   endtask

   // random sets: mostly small values, some wide values with small factors
   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct);
      int i;
      int kind;
      logic [CAND_BITS-1:0] cand;
      set_rates(send_pct, recv_pct);
      for (i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         if (kind <= 5)
            cand = $urandom_range(1023);
         else if (kind <= 7)
            cand = $urandom_range(63);
         else if (kind == 8)
            cand = $urandom & ~32'd1;
         else
            cand = 32'(3 * $urandom_range(1431655765));
         send_request(cand, ($urandom_range(5) == 0));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_values();
      test_medium_primes();
      test_output_holdoff();
      test_random_traffic(28, 0, 0);
      test_random_traffic(28, 53, 0);
      test_random_traffic(28, 0, 53);
      test_random_traffic(28, 9, 9);
      req_valid <= 1'b0;
      set_rates(0, 0);
      // drain outstanding responses, then watch for strays
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("trial_division_prime_counter_top_tb passed");
      else
         $display("trial_division_prime_counter_top_tb failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tdpc_pkg.sv
rtl/core/tdpc_ctrl.sv
rtl/core/tdpc_datapath.sv
rtl/core/trial_division_prime_counter_top.sv
tb/trial_division_prime_counter_top_tb.sv
